[rtl/wrms_pkg.sv]
// ----------------------------------------------------------------------------
// wrms_pkg
// Shared types and constants for the 4x4 sliding-window rms filter.
// ----------------------------------------------------------------------------
package wrms_pkg;

	// geometry
	localparam int MAX_LINE = 256;
	localparam int WIN      = 4;
	localparam int LINES    = WIN - 1;

	// field and counter widths
	localparam int PIX_W   = 8;
	localparam int WIDTH_W = 9;
	localparam int COL_W   = 8;
	localparam int ROW_W   = 2;
	localparam int SUM_W   = 20;
	localparam int ROOT_W  = 10;
	localparam int IDX_W   = 4;

	// line-store word: one byte per stored row, oldest row in the low byte
	localparam int LS_W = LINES * PIX_W;

	localparam logic [WIDTH_W-1:0] WIDTH_MIN   = WIDTH_W'(WIN);
	localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_LINE);
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = WIDTH_W'(MAX_LINE);
	localparam logic [ROW_W-1:0]   ROW_LAST    = ROW_W'(LINES);
	localparam logic [WIDTH_W-1:0] COL_FIRST   = WIDTH_W'(LINES);
	localparam logic [IDX_W-1:0]   IDX_LAST    = IDX_W'(WIN * WIN - 1);

	// input word
	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             start_of_frame;
	} in_word_t;

	// result word
	typedef struct packed {
		logic [PIX_W-1:0] rms_value;
		logic             window_valid;
	} out_word_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SUM,
		ST_START,
		ST_ROOT,
		ST_EMIT
	} state_t;

endpackage

[rtl/window_rms_filter_4x4_top.sv]
// ----------------------------------------------------------------------------
// window_rms_filter_4x4_top
// Sliding 4x4 window rms filter over a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one word per pixel (pixel, start_of_frame) in raster order;
//                 start_of_frame puts the position back to row 0, column 0.
//   out channel : one word per input word (rms_value, window_valid); the rms
//                 is floor(isqrt(sum of squares) / 4), zero with no full window.
//   cfg channel : line_width, always ready; write it only while the block is
//                 idle. Values are clamped to 4..256.
// Throughput: one pixel at a time. A pixel with a full window goes through
//   load, square-and-accumulate through one 8x8 multiplier, bit-serial
//   square root and hand-off; a pixel without a full window goes from load
//   straight to hand-off. The line store is a 256 x 24 memory read in the
//   accept cycle and written back the cycle after.
// Reset: position, window and line_width (256) are cleared at once; the line
//   store content is undefined until written and needs no clearing pass.
// Stall: the result sits in an output register; the next pixel is accepted
//   while it waits, and its processing holds before hand-off until it is taken.
// ----------------------------------------------------------------------------
module window_rms_filter_4x4_top (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  wrms_pkg::in_word_t         in_data,
	output logic                       out_valid,
	input  logic                       out_ready,
	output wrms_pkg::out_word_t        out_data,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [wrms_pkg::WIDTH_W-1:0] cfg_data
);
	import wrms_pkg::*;

	state_t state_q, state_d;

	logic [WIDTH_W-1:0] line_width_q;
	logic [WIDTH_W-1:0] width_use;
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;

	logic [WIDTH_W-1:0] c0, c1, cn;
	logic [ROW_W-1:0]   r0, r1, r1_inc;
	logic               win_ok;
	logic               take;

	logic [LS_W-1:0]    line_mem [MAX_LINE];
	logic [LS_W-1:0]    rd_word_s1;
	logic [COL_W-1:0]   col_s1;
	logic [PIX_W-1:0]   pix_s1;
	logic               valid_s1;

	logic [PIX_W-1:0]   win_q [WIN][WIN];
	logic [PIX_W-1:0]   column [WIN];

	logic [IDX_W-1:0]   idx_q;
	logic [PIX_W-1:0]   sq_pix;
	logic [2*PIX_W-1:0] sq;
	logic [SUM_W-1:0]   sum_q;

	logic               root_start;
	logic               root_done;
	logic [ROOT_W-1:0]  root;
	logic [PIX_W-1:0]   rms_q;

	logic               out_free;
	logic               emit;
	logic               out_valid_q;
	out_word_t          out_data_q;

	// config register
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= WIDTH_RESET;
		end else if (cfg_valid) begin
			line_width_q <= cfg_data;
		end
	end

	// width in use
	always_comb begin
		width_use = line_width_q;
		if (line_width_q < WIDTH_MIN) width_use = WIDTH_MIN;
		if (line_width_q > WIDTH_MAX) width_use = WIDTH_MAX;
	end

	// position of the incoming pixel and the one after it
	always_comb begin
		c0 = in_data.start_of_frame ? '0 : {1'b0, col_q};
		r0 = in_data.start_of_frame ? '0 : row_q;
		if (c0 >= width_use) begin
			c1 = '0;
			r1 = (r0 == ROW_LAST) ? r0 : r0 + ROW_W'(1);
		end else begin
			c1 = c0;
			r1 = r0;
		end
		r1_inc = (r1 == ROW_LAST) ? r1 : r1 + ROW_W'(1);
		cn     = c1 + WIDTH_W'(1);
		win_ok = (r1 == ROW_LAST) && (c1 >= COL_FIRST);
	end

	assign take = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (cn >= width_use) begin
				col_q <= '0;
				row_q <= r1_inc;
			end else begin
				col_q <= cn[COL_W-1:0];
				row_q <= r1;
			end
		end
	end

	// accepted word held for the load cycle
	always_ff @(posedge clk) begin
		if (take) begin
			col_s1   <= c1[COL_W-1:0];
			pix_s1   <= in_data.pixel;
			valid_s1 <= win_ok;
		end
	end

	// line store: read in the accept cycle, shifted word written back next cycle
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			line_mem[col_s1] <= {pix_s1, rd_word_s1[LS_W-1:PIX_W]};
		end
		if (take) begin
			rd_word_s1 <= line_mem[c1[COL_W-1:0]];
		end
	end

	// new window column, oldest row on top
	always_comb begin
		for (int r = 0; r < LINES; r++) begin
			column[r] = rd_word_s1[r*PIX_W +: PIX_W];
		end
		column[LINES] = pix_s1;
	end

	// window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < WIN; r++) begin
				for (int c = 0; c < WIN; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (state_q == ST_LOAD) begin
			for (int r = 0; r < WIN; r++) begin
				for (int c = 0; c < WIN - 1; c++) begin
					win_q[r][c] <= win_q[r][c+1];
				end
				win_q[r][WIN-1] <= column[r];
			end
		end
	end

	// sum of squares, one window pixel a cycle
	assign sq_pix = win_q[idx_q[IDX_W-1:2]][idx_q[1:0]];
	assign sq     = (2*PIX_W)'(sq_pix) * (2*PIX_W)'(sq_pix);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (state_q == ST_SUM) begin
			idx_q <= idx_q + IDX_W'(1);
		end else begin
			idx_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			sum_q <= '0;
		end else if (state_q == ST_SUM) begin
			sum_q <= sum_q + SUM_W'(sq);
		end
	end

	// square root
	wrms_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (sum_q),
		.done     (root_done),
		.root     (root)
	);

	// result value: root / 4, or zero without a full window
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD) begin
			rms_q <= '0;
		end else if (state_q == ST_ROOT && root_done) begin
			rms_q <= root[ROOT_W-1:2];
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		root_start = 1'b0;
		emit       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) state_d = ST_LOAD;
			end
			ST_LOAD: begin
				state_d = valid_s1 ? ST_SUM : ST_EMIT;
			end
			ST_SUM: begin
				if (idx_q == IDX_LAST) state_d = ST_START;
			end
			ST_START: begin
				root_start = 1'b1;
				state_d    = ST_ROOT;
			end
			ST_ROOT: begin
				if (root_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_data_q <= '{rms_value: rms_q, window_valid: valid_s1};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[rtl/wrms_isqrt.sv]
// ----------------------------------------------------------------------------
// wrms_isqrt
// Iterative floor square root, one result bit per cycle (digit-by-digit).
// ----------------------------------------------------------------------------
module wrms_isqrt (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [wrms_pkg::SUM_W-1:0]     radicand,
	output logic                           done,
	output logic [wrms_pkg::ROOT_W-1:0]    root
);
	import wrms_pkg::*;

	localparam logic [SUM_W-2:0] BIT_TOP = (SUM_W-1)'(1) << (SUM_W - 2);

	logic [SUM_W-1:0] rem_q;
	logic [SUM_W-1:0] root_q;
	logic [SUM_W-2:0] bit_q;
	logic             busy_q;
	logic             done_q;
	logic [SUM_W:0]   trial;
	logic             fits;

	// trial subtraction for the current bit pair
	assign trial = {1'b0, root_q} + {2'b00, bit_q};
	assign fits  = ({1'b0, rem_q} >= trial);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q == (SUM_W-1)'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= radicand;
			root_q <= '0;
			bit_q  <= BIT_TOP;
		end else if (busy_q) begin
			if (fits) begin
				rem_q  <= rem_q - trial[SUM_W-1:0];
				root_q <= (root_q >> 1) + {1'b0, bit_q};
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = root_q[ROOT_W-1:0];

endmodule

[bench/window_rms_filter_4x4_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// window_rms_filter_4x4_top_test
// Drives pixel frames through the 4x4 window rms filter under random idling
// on both sides, predicts every output word from a behavioral copy of the line
// stores and window, and compares each word as it is taken.
// ----------------------------------------------------------------------------
module window_rms_filter_4x4_top_test;
	import wrms_pkg::*;

	localparam int DRAIN_CYCLES = 40;
	localparam int TIMEOUT_NS   = 2000000;
	localparam int RANDOM_WORDS = 1400;
	localparam int REPORT_LIMIT = 10;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 in_valid  = 1'b0;
	logic                 in_ready;
	in_word_t             in_data   = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	out_word_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [WIDTH_W-1:0]   cfg_data  = '0;

	// predicted filter state
	bit [PIX_W-1:0]   line_mem [LINES][MAX_LINE];
	bit [PIX_W-1:0]   win_pix [WIN][WIN];
	bit [WIDTH_W-1:0] width_reg = WIDTH_RESET;
	int unsigned      col_pos = 0;
	int unsigned      row_pos = 0;

	out_word_t   rms_expected [$];
	bit          no_idle = 1'b0;
	int unsigned width_now = MAX_LINE;
	int unsigned fault_count = 0;
	int unsigned pixels_sent = 0;
	int unsigned words_checked = 0;
	int unsigned full_windows = 0;
	int unsigned width_writes = 0;

	window_rms_filter_4x4_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// hard stop
	initial begin
		#(TIMEOUT_NS);
		$display("window_rms_filter_4x4_top_test NOT OK");
		$finish;
	end

	// receiver idles at random outside the steady stretch
	always @(negedge clk) begin
		out_ready <= no_idle || ($urandom_range(99) >= 17);
	end

	function automatic int unsigned clamp_span(input logic [WIDTH_W-1:0] v);
		int unsigned span;
		span = 32'(v);
		if (span < WIN) span = WIN;
		if (span > MAX_LINE) span = MAX_LINE;
		return span;
	endfunction

	// exact floor square root; sums stay below 2**20
	function automatic int unsigned floor_root(input int unsigned v);
		int unsigned r, t;
		int b;
		r = 0;
		for (b = 9; b >= 0; b--) begin
			t = r | (32'd1 << b);
			if (t * t <= v) r = t;
		end
		return r;
	endfunction

	function automatic void advance_line();
		col_pos = 0;
		if (row_pos < LINES) row_pos++;
	endfunction

	// one pixel in, one predicted rms word out
	task automatic rms_predict(input in_word_t w, output out_word_t r);
		int unsigned span, c, acc;
		bit [PIX_W-1:0] fresh [WIN];
		span = clamp_span(width_reg);
		if (w.start_of_frame) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= span) advance_line();
		c = col_pos;

		// column of the window: three stored rows plus the new pixel
		for (int k = 0; k < LINES; k++) fresh[k] = line_mem[k][c];
		fresh[LINES] = w.pixel;
		for (int k = 0; k < LINES - 1; k++) line_mem[k][c] = line_mem[k + 1][c];
		line_mem[LINES - 1][c] = w.pixel;

		// shift window left and append the column
		for (int rr = 0; rr < WIN; rr++) begin
			for (int cc = 0; cc < WIN - 1; cc++) win_pix[rr][cc] = win_pix[rr][cc + 1];
			win_pix[rr][WIN - 1] = fresh[rr];
		end

		r = '0;
		if (row_pos >= LINES && c >= LINES) begin
			acc = 0;
			for (int rr = 0; rr < WIN; rr++)
				for (int cc = 0; cc < WIN; cc++)
					acc += 32'(win_pix[rr][cc]) * 32'(win_pix[rr][cc]);
			r.rms_value    = PIX_W'(floor_root(acc) / WIN);
			r.window_valid = 1'b1;
		end

		col_pos = c + 1;
		if (col_pos >= span) advance_line();
	endtask

	// track accepted words and check results against predictions
	always @(posedge clk) begin : track_words
		out_word_t predicted;
		out_word_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) width_reg = cfg_data;
			if (in_valid && in_ready) begin
				rms_predict(in_data, predicted);
				rms_expected.push_back(predicted);
				if (predicted.window_valid) full_windows++;
			end
			if (out_valid && out_ready) begin
				words_checked++;
				if (rms_expected.size() == 0) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT)
						$display("%0t: unexpected word rms %0d valid %0b",
							$time, out_data.rms_value, out_data.window_valid);
				end else begin
					want = rms_expected.pop_front();
					if (out_data.rms_value !== want.rms_value ||
						out_data.window_valid !== want.window_valid) begin
						fault_count++;
						if (fault_count <= REPORT_LIMIT)
							$display("%0t: mismatch, expected rms %0d valid %0b, got rms %0d valid %0b",
								$time, want.rms_value, want.window_valid,
								out_data.rms_value, out_data.window_valid);
					end
				end
			end
		end
	end

	// offer one pixel word, return at the edge that takes it
	task automatic send_pixel(input logic [PIX_W-1:0] px, input logic sof);
		@(negedge clk);
		while (!no_idle && $urandom_range(99) < 17) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= '{pixel: px, start_of_frame: sof};
		do @(posedge clk); while (!in_ready);
		pixels_sent++;
	endtask

	// stop sending and let every outstanding word come back
	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (rms_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_width(input logic [WIDTH_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		width_writes++;
	endtask

	function automatic logic [PIX_W-1:0] pick_pixel();
		int unsigned k;
		k = $urandom_range(99);
		if (k < 10) return '1;
		if (k < 20) return '0;
		if (k < 25) return PIX_W'($urandom_range(15));
		return PIX_W'($urandom_range(255));
	endfunction

	// narrowest frame filled with full-scale pixels
	task automatic test_full_scale_window();
		write_width(WIDTH_W'(WIN));
		width_now = WIN;
		send_pixel('1, 1'b1);
		repeat (WIN * WIN - 1) send_pixel('1, 1'b0);
	endtask

	// zeros entering a saturated window, then a new frame
	task automatic test_zero_fill_and_restart();
		repeat (WIN) send_pixel('0, 1'b0);
		send_pixel('0, 1'b1);
	endtask

	// width dropped below the current column, and below the minimum
	task automatic test_width_lowered_mid_row();
		wait_drain();
		write_width(WIDTH_W'(8));
		send_pixel(pick_pixel(), 1'b1);
		repeat (6) send_pixel(pick_pixel(), 1'b0);
		wait_drain();
		write_width(WIDTH_W'(3));
		width_now = clamp_span(WIDTH_W'(3));
		repeat (2) send_pixel(pick_pixel(), 1'b0);
	endtask

	// frames of random width and content, with some broken ones
	task automatic test_random_frames();
		int unsigned sent, phase, len, eff, k;
		logic [WIDTH_W-1:0] v;
		logic raise, sof;
		sent  = 0;
		phase = 0;
		while (sent < RANDOM_WORDS) begin
			k = $urandom_range(99);
			if (phase == 0) v = '0;
			else if (phase == 1) v = '1;
			else if (k < 6) v = WIDTH_W'($urandom_range(3));
			else if (k < 10) v = WIDTH_W'($urandom_range(511, 257));
			else if (k < 14) v = WIDTH_W'($urandom_range(256, 33));
			else v = WIDTH_W'($urandom_range(20, 4));
			eff = clamp_span(v);

			// one full frame at the widest line, short runs at other large widths
			if (phase == 1) len = LINES * eff + 20;
			else if (eff > 32) len = $urandom_range(40, 8);
			else len = eff * $urandom_range(6, 1) + $urandom_range(eff);

			wait_drain();
			write_width(v);
			// a wider line needs a fresh frame so no unwritten store is read
			raise     = eff > width_now;
			width_now = eff;

			for (int i = 0; i < len; i++) begin
				if (i == 0) sof = raise || $urandom_range(1);
				else sof = ($urandom_range(99) < 2);
				no_idle = (sent >= 500 && sent < 800);
				if (i > 0 && $urandom_range(99) < 3) wait_drain();
				send_pixel(pick_pixel(), sof);
				sent++;
			end
			phase++;
		end
		no_idle = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_full_scale_window();
		test_zero_fill_and_restart();
		test_width_lowered_mid_row();
		test_random_frames();
		wait_drain();

		$display("run covered %0d pixels and %0d checked words, %0d of them full windows,",
			pixels_sent, words_checked, full_windows);
		$display("over %0d line width settings from clamped minimum to clamped maximum",
			width_writes);
		if (fault_count == 0 && rms_expected.size() == 0) begin
			$display("window_rms_filter_4x4_top_test OK");
		end else begin
			$display("%0d faults, %0d words outstanding", fault_count, rms_expected.size());
			$display("window_rms_filter_4x4_top_test NOT OK");
		end
		$finish;
	end

endmodule
